FILE: rtl/ssm_pkg.sv
package ssm_pkg;

  localparam int ORDER       = 6;
  localparam int NCOL        = ORDER + 1;
  localparam int STATE_W     = 32;
  localparam int TABLE_SCALE = 10000;

  typedef logic [2:0] row_t;
  typedef logic [2:0] col_t;

  // coefficients in units of 1/TABLE_SCALE, row i holds A[i][0..5] then B[i]
  localparam int COEF_TABLE [ORDER][NCOL] = '{
    '{  9652,  -172,    57,   -58,    52,  -251,  471 },
    '{  7732,  1252,  2315,   700,  1282,  7754,  377 },
    '{  8278, -7522,  -956,  3299, -4855,  3915,  404 },
    '{  9948,  2655, -3848,  4212,  3927,  2899,  485 },
    '{  7648, -4165, -4855, -3366,  -986,  7281,  373 },
    '{ 11056,  7587,  1179,   748, -2192,  1491,  539 }
  };

  // round to nearest, ties away from zero
  function automatic longint fixed_coef(int t, int frac);
    longint mag;
    longint q;
    mag = (t < 0) ? -longint'(t) : longint'(t);
    q = ((mag << frac) + (TABLE_SCALE / 2)) / TABLE_SCALE;
    return (t < 0) ? -q : q;
  endfunction

  typedef struct packed {
    logic start;
    logic clear;
    logic mac;
    row_t row;
    col_t col;
    logic first;
    logic last;
    logic out_load;
  } ssm_cmd_t;

  typedef struct packed {
    logic done;
  } ssm_status_t;

endpackage

FILE: rtl/ssm_in_if.sv
interface ssm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_in;
  logic               clear;

  modport source(output valid, output sample_in, output clear, input ready);
  modport sink(input valid, input sample_in, input clear, output ready);
endinterface

FILE: rtl/ssm_out_if.sv
interface ssm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] voltage_out;
  logic               saturated;

  modport source(output valid, output voltage_out, output saturated, input ready);
  modport sink(input valid, input voltage_out, input saturated, output ready);
endinterface

FILE: rtl/ssm_datapath.sv
module ssm_datapath import ssm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ssm_cmd_t                  cmd,
  input  logic signed [STATE_W-1:0] sample_in,
  output ssm_status_t               status,
  output logic signed [STATE_W-1:0] voltage_out,
  output logic                      saturated
);

  localparam int CW     = FRAC_BITS + 2;
  localparam int PROD_W = STATE_W + CW;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RES_W  = ACC_W - FRAC_BITS;

  logic signed [CW-1:0]      coef [ORDER][NCOL];
  logic signed [STATE_W-1:0] states [ORDER];
  logic signed [STATE_W-1:0] nxt [ORDER];
  logic signed [STATE_W-1:0] sample_reg;
  logic signed [STATE_W-1:0] operand;

  logic signed [PROD_W-1:0]  prod;
  logic                      p_valid;
  logic                      p_first;
  logic                      p_last;
  row_t                      p_row;

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   rounded;
  logic signed [RES_W-1:0]   shifted;
  logic                      a_done;
  row_t                      a_row;

  logic signed [STATE_W-1:0] row_val;
  logic                      row_clip;
  logic                      row_last;
  logic                      sat_acc;

  logic signed [STATE_W-1:0] res_val;
  logic                      res_sat;
  logic                      done;

  for (genvar r = 0; r < ORDER; r++) begin : g_row
    for (genvar c = 0; c < NCOL; c++) begin : g_col
      assign coef[r][c] = CW'(fixed_coef(COEF_TABLE[r][c], FRAC_BITS));
    end
  end

  assign operand  = (cmd.col == col_t'(ORDER)) ? sample_reg : states[cmd.col];
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // round half up, then floor shift
  assign rounded  = acc + (ACC_W'(1) << (FRAC_BITS - 1));
  assign shifted  = rounded[ACC_W-1:FRAC_BITS];

  always_comb begin
    row_clip = !((&shifted[RES_W-1:STATE_W-1]) || !(|shifted[RES_W-1:STATE_W-1]));
    if (row_clip) begin
      row_val = shifted[RES_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                 : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      row_val = shifted[STATE_W-1:0];
    end
  end

  assign row_last = (a_row == row_t'(ORDER - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      a_done  <= 1'b0;
      done    <= 1'b0;
      for (int i = 0; i < ORDER; i++) begin
        states[i] <= '0;
      end
    end else begin
      p_valid <= cmd.mac;
      a_done  <= p_valid && p_last;
      done    <= a_done && row_last;
      if (cmd.clear) begin
        for (int i = 0; i < ORDER; i++) begin
          states[i] <= '0;
        end
      end else if (a_done && row_last) begin
        for (int i = 0; i < ORDER - 1; i++) begin
          states[i] <= nxt[i];
        end
        states[ORDER-1] <= row_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample_reg <= sample_in;
    end
    if (cmd.mac) begin
      prod    <= coef[cmd.row][cmd.col] * operand;
      p_first <= cmd.first;
      p_last  <= cmd.last;
      p_row   <= cmd.row;
    end
    if (p_valid) begin
      acc   <= p_first ? prod_ext : acc + prod_ext;
      a_row <= p_row;
    end
    if (cmd.start) begin
      sat_acc <= 1'b0;
    end else if (a_done) begin
      sat_acc <= sat_acc | row_clip;
    end
    if (a_done && !row_last) begin
      nxt[a_row] <= row_val;
    end
    if (cmd.clear) begin
      res_val <= '0;
      res_sat <= 1'b0;
    end else if (a_done && row_last) begin
      res_val <= row_val;
      res_sat <= sat_acc | row_clip;
    end
    if (cmd.out_load) begin
      voltage_out <= res_val;
      saturated   <= res_sat;
    end
  end

  assign status.done = done;

endmodule

FILE: rtl/ssm_ctrl.sv
module ssm_ctrl import ssm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_clear,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  input  ssm_status_t status,
  output ssm_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    LOAD
  } state_t;

  state_t state;
  row_t   row;
  col_t   col;
  logic   in_fire;
  logic   load_ok;

  assign in_ready = (state == IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = (state == LOAD) && (!out_valid || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.start    = in_fire && !in_clear;
    cmd.clear    = in_fire && in_clear;
    cmd.mac      = (state == RUN);
    cmd.row      = row;
    cmd.col      = col;
    cmd.first    = (col == '0);
    cmd.last     = (col == col_t'(NCOL - 1));
    cmd.out_load = load_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          row <= '0;
          col <= '0;
          if (in_fire) begin
            state <= in_clear ? LOAD : RUN;
          end
        end
        RUN: begin
          if (col == col_t'(NCOL - 1)) begin
            col <= '0;
            row <= row + row_t'(1);
            if (row == row_t'(ORDER - 1)) begin
              state <= DRAIN;
            end
          end else begin
            col <= col + col_t'(1);
          end
        end
        DRAIN: begin
          if (status.done) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          if (load_ok) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/state_space_model_step_unit.sv
// Sixth-order discrete state-space model step: each item with clear low computes
// x(k+1) = A*x(k) + B*u(k) with fixed Q2.FRAC_BITS coefficients over Q16.16 state
// and input, rounds each row half up, saturates it to 32 bits and returns the sixth
// new state with a flag that is set if any row clipped. An item with clear high
// zeroes the six states and returns zero. A normal step runs its 42 products
// through one shared multiply-accumulate, one product a cycle, then drains the
// multiply and accumulate registers; the result is then loaded into the output
// register, and the next item is taken only after that load. The result sits in
// an output register, so a new item may start while it waits.
module state_space_model_step_unit import ssm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  ssm_in_if.sink    in_ch,
  ssm_out_if.source out_ch
);

  ssm_cmd_t    cmd;
  ssm_status_t status;

  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_clear  (in_ch.clear),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  ssm_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample_in   (in_ch.sample_in),
    .status      (status),
    .voltage_out (out_ch.voltage_out),
    .saturated   (out_ch.saturated)
  );

endmodule

FILE: bench/state_space_model_step_unit_tb.sv
module state_space_model_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssm_pkg::*;

  localparam int FRAC        = 16;
  localparam int N_RANDOM    = 1200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 60;

  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] sample;
    logic               clear;
    bit                 hold;
    int                 src_idle;
    int                 snk_idle;
  } sample_item_t;

  typedef struct {
    logic signed [31:0] volts;
    logic               clipped;
  } volt_exp_t;

  logic clk = 1'b0;
  logic rst;

  ssm_in_if  in_ch();
  ssm_out_if out_ch();

  state_space_model_step_unit #(.FRAC_BITS(FRAC)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  sample_item_t       sample_queue[$];
  volt_exp_t          expected_volts[$];
  logic signed [31:0] plant_x [ORDER];
  int                 queued = 0;
  int                 err_count = 0;
  int                 quiet_cycles = 0;
  int                 src_idle = 0;
  int                 snk_idle = 0;
  bit                 in_fire = 1'b0;

  // table entry to Q2.FRAC, nearest with ties away from zero
  function automatic longint to_q2(int t);
    longint mag;
    longint q;
    mag = longint'(t);
    if (mag < 0) mag = -mag;
    q = (2 * (mag <<< FRAC) + TABLE_SCALE) / (2 * TABLE_SCALE);
    return (t < 0) ? -q : q;
  endfunction

  function automatic void advance_plant(input logic signed [31:0] u, input logic clr,
                                        output logic signed [31:0] volts,
                                        output logic clipped);
    logic signed [31:0] nxt [ORDER];
    longint acc;
    longint r;
    clipped = 1'b0;
    volts = '0;
    if (clr) begin
      foreach (plant_x[i]) plant_x[i] = '0;
      return;
    end
    for (int i = 0; i < ORDER; i++) begin
      acc = 0;
      for (int j = 0; j < ORDER; j++)
        acc += to_q2(COEF_TABLE[i][j]) * longint'(plant_x[j]);
      acc += to_q2(COEF_TABLE[i][ORDER]) * longint'(u);
      r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        clipped = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        clipped = 1'b1;
      end
      nxt[i] = r[31:0];
    end
    foreach (plant_x[i]) plant_x[i] = nxt[i];
    volts = plant_x[ORDER - 1];
  endfunction

  function automatic void add_item(logic signed [31:0] s, logic clr, bit hold);
    sample_item_t it;
    it.sample = s;
    it.clear  = clr;
    it.hold   = hold;
    if (queued < 400) begin
      it.src_idle = 14;
      it.snk_idle = 62;
    end else if (queued < 800) begin
      it.src_idle = 62;
      it.snk_idle = 14;
    end else begin
      it.src_idle = 0;
      it.snk_idle = 0;
    end
    sample_queue.push_back(it);
    queued++;
  endfunction

  // driver
  always @(negedge clk) begin
    sample_item_t       it;
    logic               nv;
    logic signed [31:0] ns;
    logic               nc;
    if (rst) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      nv = in_ch.valid && !in_fire;
      ns = in_ch.sample_in;
      nc = in_ch.clear;
      if (!nv) begin
        ns = $urandom;
        nc = 1'($urandom_range(1));
        if (sample_queue.size() > 0) begin
          it = sample_queue[0];
          src_idle = it.src_idle;
          snk_idle = it.snk_idle;
          // a held item waits for every result to drain
          if (!(it.hold && expected_volts.size() != 0) &&
              $urandom_range(99) >= src_idle) begin
            void'(sample_queue.pop_front());
            nv = 1'b1;
            ns = it.sample;
            nc = it.clear;
          end
        end
      end
      in_ch.valid     <= nv;
      in_ch.sample_in <= ns;
      in_ch.clear     <= nc;
      out_ch.ready    <= ($urandom_range(99) >= snk_idle);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    volt_exp_t          e;
    logic signed [31:0] v;
    logic               s;
    bit                 out_fire;
    in_fire  = !rst && in_ch.valid && in_ch.ready;
    out_fire = !rst && out_ch.valid && out_ch.ready;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_fire) begin
        if (expected_volts.size() == 0) begin
          $error("unexpected item: voltage_out %0d saturated %0b",
                 out_ch.voltage_out, out_ch.saturated);
          err_count++;
        end else begin
          e = expected_volts.pop_front();
          if (out_ch.voltage_out !== e.volts) begin
            $error("voltage_out: expected %0d, got %0d", e.volts, out_ch.voltage_out);
            err_count++;
          end
          if (out_ch.saturated !== e.clipped) begin
            $error("saturated: expected %0b, got %0b", e.clipped, out_ch.saturated);
            err_count++;
          end
        end
      end
      if (in_fire) begin
        advance_plant(in_ch.sample_in, in_ch.clear, v, s);
        e.volts   = v;
        e.clipped = s;
        expected_volts.push_back(e);
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    int                 kind;
    int                 len;
    int                 mode;
    logic signed [31:0] ext;
    logic signed [31:0] s;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    in_ch.clear = 1'b0;
    out_ch.ready = 1'b0;
    foreach (plant_x[i]) plant_x[i] = '0;

    // directed
    add_item(S_MAX, 1'b1, 1'b0);
    add_item(32'sd0, 1'b0, 1'b0);
    add_item(32'sd1, 1'b0, 1'b0);
    add_item(-32'sd1, 1'b0, 1'b0);
    add_item(S_MAX, 1'b0, 1'b0);
    add_item(S_MIN, 1'b0, 1'b0);
    add_item(32'sh8000_0001, 1'b0, 1'b0);
    add_item(32'sh0001_0000, 1'b0, 1'b0);
    add_item(32'shffff_0000, 1'b0, 1'b0);
    for (int k = 0; k < 10; k++) add_item(S_MAX, 1'b0, 1'b0);
    add_item(S_MIN, 1'b1, 1'b1);
    for (int k = 0; k < 3; k++) add_item(S_MIN, 1'b0, 1'b0);
    add_item(32'sd0, 1'b1, 1'b0);

    // random runs between clears, with some stray items
    while (queued < N_RANDOM + 24) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        add_item($urandom, 1'b1, 1'b0);
      end else if (kind == 1) begin
        add_item($urandom, 1'($urandom_range(1)), 1'b0);
      end else begin
        if ($urandom_range(1)) add_item($urandom, 1'b1, 1'b0);
        len  = $urandom_range(60, 5);
        mode = $urandom_range(3);
        ext  = $urandom_range(1) ? S_MAX : S_MIN;
        for (int k = 0; k < len; k++) begin
          case (mode)
            0: s = $urandom;
            1: s = 32'($urandom_range(262143)) - 32'd131072;
            2: s = ext;
            default: s = k[0] ? S_MAX : S_MIN;
          endcase
          add_item(s, 1'b0, (queued % 150) == 0);
        end
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(sample_queue.size() == 0 && !in_ch.valid && expected_volts.size() == 0)
           && quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    if (quiet_cycles < QUIET_LIMIT)
      repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_volts.size() != 0) begin
      $error("%0d expected items never arrived", expected_volts.size());
      err_count++;
    end
    if (err_count == 0 && quiet_cycles < QUIET_LIMIT)
      $display("state_space_model_step_unit_tb OK");
    else
      $display("state_space_model_step_unit_tb NOT OK");
    $finish;
  end

endmodule
